// File: rtl/core/mpawb_pkg.sv
// ----------------------------------------------------------------------------
// Memory port arbiter and write buffer package
// Shared types, codes and a helper function for the arbiter and its top level.
// ----------------------------------------------------------------------------
package mpawb_pkg;

    localparam int MAX_BLOCK_WORDS = 16;
    localparam int SLOT_W          = $clog2(MAX_BLOCK_WORDS);

    // Item operation codes.
    localparam logic [1:0] OP_TICK    = 2'd0;
    localparam logic [1:0] OP_LOAD    = 2'd1;
    localparam logic [1:0] OP_ENQUEUE = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_WRITE_BACK     = 2'd0;
    localparam logic [1:0] CFG_FIRST_PENALTY  = 2'd1;
    localparam logic [1:0] CFG_LATER_PENALTY  = 2'd2;
    localparam logic [1:0] CFG_BLOCK_WORDS    = 2'd3;

    // Reported owner codes.
    localparam logic [1:0] STATE_IDLE  = 2'd0;
    localparam logic [1:0] STATE_DATA  = 2'd1;
    localparam logic [1:0] STATE_INSTR = 2'd2;
    localparam logic [1:0] STATE_WRITE = 2'd3;

    typedef enum logic [3:0] {
        OWN_IDLE  = 4'b0001,
        OWN_DATA  = 4'b0010,
        OWN_INSTR = 4'b0100,
        OWN_WRITE = 4'b1000
    } t_owner;

    typedef struct packed {
        t_owner owner;
        logic   d_req;
        logic   i_req;
        logic   busy;
    } t_arb_req;

    function automatic logic [1:0] owner_code(input t_owner owner);
        logic [1:0] code;
        unique case (owner)
            OWN_IDLE:  code = STATE_IDLE;
            OWN_DATA:  code = STATE_DATA;
            OWN_INSTR: code = STATE_INSTR;
            OWN_WRITE: code = STATE_WRITE;
            default:   code = STATE_IDLE;
        endcase
        return code;
    endfunction

endpackage

// File: rtl/core/mpawb_arb.sv
// ----------------------------------------------------------------------------
// Memory port owner arbiter
// Next-owner logic: idle grants data, then instruction, then the write buffer;
// a busy owner keeps the port while it still asks for it.
// ----------------------------------------------------------------------------
module mpawb_arb import mpawb_pkg::*; (
    input  t_arb_req i_req,
    output t_owner   o_next_owner
);

    always_comb begin
        o_next_owner = i_req.owner;
        unique case (i_req.owner)
            OWN_IDLE: begin
                if (i_req.d_req)      o_next_owner = OWN_DATA;
                else if (i_req.i_req) o_next_owner = OWN_INSTR;
                else if (i_req.busy)  o_next_owner = OWN_WRITE;
            end
            OWN_DATA: begin
                if (!i_req.d_req) begin
                    if (i_req.i_req)     o_next_owner = OWN_INSTR;
                    else if (i_req.busy) o_next_owner = OWN_WRITE;
                    else                 o_next_owner = OWN_IDLE;
                end
            end
            OWN_INSTR: begin
                if (!i_req.i_req) begin
                    if (i_req.d_req)     o_next_owner = OWN_DATA;
                    else if (i_req.busy) o_next_owner = OWN_WRITE;
                    else                 o_next_owner = OWN_IDLE;
                end
            end
            OWN_WRITE: begin
                if (!i_req.busy) begin
                    if (i_req.d_req)      o_next_owner = OWN_DATA;
                    else if (i_req.i_req) o_next_owner = OWN_INSTR;
                    else                  o_next_owner = OWN_IDLE;
                end
            end
            default: o_next_owner = OWN_IDLE;
        endcase
    end

endmodule

// File: rtl/core/memory_port_arbiter_write_buffer_unit.sv
// ----------------------------------------------------------------------------
// Memory port arbiter with one-entry write buffer
// Shares one memory port between data fills, instruction fills and a buffered
// write-back burst or write-through word.
// ----------------------------------------------------------------------------
// Every accepted item produces exactly one result in the next cycle. The owner
// machine, the penalty counter and the buffer update are all resolved in the
// cycle the item is taken, and the result sits in an output register, so a new
// item is accepted every clock whenever the output register is empty or being
// drained. Configuration writes are always taken; o_cfg_ready is tied high.
module memory_port_arbiter_write_buffer_unit import mpawb_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,

    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_op,
    input  logic        i_d_fetching,
    input  logic        i_i_fetching,
    input  logic [3:0]  i_word_index,
    input  logic [31:0] i_word_data,
    input  logic [31:0] i_enqueue_address,
    input  logic        i_block_all_valid,

    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_mem_state,
    output logic        o_enqueue_accepted,
    output logic        o_mem_write_valid,
    output logic [31:0] o_mem_write_address,
    output logic [31:0] o_mem_write_data,
    output logic        o_buffer_busy,
    output logic [31:0] o_pending_address
);

    // Configuration.
    logic        r_write_back;
    logic [7:0]  r_first_penalty;
    logic [7:0]  r_later_penalty;
    logic [4:0]  r_block_words;

    // Buffer state.
    t_owner            r_owner, n_owner;
    logic              r_busy, n_busy;
    logic [7:0]        r_wait, n_wait;
    logic [SLOT_W-1:0] r_pos, n_pos;
    logic [31:0]       r_addr, n_addr;
    logic [31:0]       r_words [MAX_BLOCK_WORDS];

    // Output register.
    logic        r_out_valid;
    logic [1:0]  r_mem_state, n_mem_state;
    logic        r_accepted, n_accepted;
    logic        r_wr_valid, n_wr_valid;
    logic [31:0] r_wr_addr, n_wr_addr;
    logic [31:0] r_wr_data, n_wr_data;
    logic        r_busy_out, n_busy_out;
    logic [31:0] r_pend_addr, n_pend_addr;

    logic              in_fire;
    t_arb_req          arb_req;
    t_owner            arb_owner;
    logic [SLOT_W-1:0] last_pos;
    logic [31:0]       blk_mask;
    logic [7:0]        wait_inc;
    logic              fire;
    logic              more;
    logic              load_we;
    logic              enq_ok;
    logic [SLOT_W-1:0] load_slot;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_fire     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_write_back    <= 1'b1;
            r_first_penalty <= 8'd30;
            r_later_penalty <= 8'd2;
            r_block_words   <= 5'd4;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_WRITE_BACK:    r_write_back    <= i_cfg_data[0];
                CFG_FIRST_PENALTY: r_first_penalty <= i_cfg_data;
                CFG_LATER_PENALTY: r_later_penalty <= i_cfg_data;
                CFG_BLOCK_WORDS:   r_block_words   <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    // Last burst slot, with zero treated as one word and large sizes saturated.
    always_comb begin
        if (r_block_words == 5'd0) begin
            last_pos = '0;
        end else if (r_block_words > 5'(MAX_BLOCK_WORDS)) begin
            last_pos = SLOT_W'(MAX_BLOCK_WORDS - 1);
        end else begin
            last_pos = SLOT_W'(r_block_words - 5'd1);
        end
    end

    // The block span rounds up to a power of two before aligning the address.
    always_comb begin
        priority if (last_pos == '0)        blk_mask = ~32'h3;
        else if (last_pos == SLOT_W'(1))    blk_mask = ~32'h7;
        else if (last_pos <= SLOT_W'(3))    blk_mask = ~32'hf;
        else if (last_pos <= SLOT_W'(7))    blk_mask = ~32'h1f;
        else                                blk_mask = ~32'h3f;
    end

    assign arb_req = '{owner: r_owner, d_req: i_d_fetching, i_req: i_i_fetching,
                       busy: r_busy};

    mpawb_arb u_arb (
        .i_req        (arb_req),
        .o_next_owner (arb_owner)
    );

    assign wait_inc  = r_wait + 8'd1;
    assign load_slot = i_word_index[SLOT_W-1:0];

    always_comb begin
        n_owner    = r_owner;
        n_busy     = r_busy;
        n_wait     = r_wait;
        n_pos      = r_pos;
        n_addr     = r_addr;
        n_accepted = 1'b0;
        n_wr_valid = 1'b0;
        n_wr_addr  = '0;
        n_wr_data  = '0;
        fire       = 1'b0;
        more       = 1'b0;
        load_we    = 1'b0;
        enq_ok     = 1'b0;
        unique case (i_op)
            OP_TICK: begin
                n_owner = arb_owner;
                if (r_busy && arb_owner == OWN_WRITE) begin
                    fire   = (r_pos == '0) ? (wait_inc == r_first_penalty)
                                           : (wait_inc == r_later_penalty);
                    n_wait = wait_inc;
                    if (fire) begin
                        n_wr_valid = 1'b1;
                        n_wr_addr  = r_addr;
                        n_wr_data  = r_words[r_pos];
                        n_wait     = '0;
                        more = (r_pos == '0) ? (r_write_back && last_pos != '0)
                                             : (r_pos != last_pos);
                        if (more) begin
                            n_addr = r_addr + 32'd4;
                            n_pos  = r_pos + SLOT_W'(1);
                        end else begin
                            n_busy  = 1'b0;
                            n_owner = OWN_IDLE;
                        end
                    end
                end
            end
            OP_LOAD: begin
                load_we = !r_busy && (32'(i_word_index) < 32'(MAX_BLOCK_WORDS));
            end
            OP_ENQUEUE: begin
                enq_ok = !r_busy && i_block_all_valid;
                if (enq_ok) begin
                    n_addr     = r_write_back ? (i_enqueue_address & blk_mask)
                                              : i_enqueue_address;
                    n_busy     = 1'b1;
                    n_wait     = '0;
                    n_pos      = '0;
                    n_accepted = 1'b1;
                end
            end
            default: ;
        endcase
        n_mem_state = owner_code(n_owner);
        n_busy_out  = n_busy;
        n_pend_addr = n_busy ? n_addr : 32'hffff_ffff;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owner     <= OWN_IDLE;
            r_busy      <= 1'b0;
            r_wait      <= '0;
            r_pos       <= '0;
            r_addr      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_fire) begin
                r_owner <= n_owner;
                r_busy  <= n_busy;
                r_wait  <= n_wait;
                r_pos   <= n_pos;
                r_addr  <= n_addr;
            end
            if (in_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Buffer words: a write-through enqueue stages its word in slot zero.
    always_ff @(posedge i_clk) begin
        if (in_fire && load_we) begin
            r_words[load_slot] <= i_word_data;
        end else if (in_fire && enq_ok && !r_write_back) begin
            r_words[0] <= i_word_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_mem_state <= n_mem_state;
            r_accepted  <= n_accepted;
            r_wr_valid  <= n_wr_valid;
            r_wr_addr   <= n_wr_addr;
            r_wr_data   <= n_wr_data;
            r_busy_out  <= n_busy_out;
            r_pend_addr <= n_pend_addr;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_mem_state         = r_mem_state;
    assign o_enqueue_accepted  = r_accepted;
    assign o_mem_write_valid   = r_wr_valid;
    assign o_mem_write_address = r_wr_addr;
    assign o_mem_write_data    = r_wr_data;
    assign o_buffer_busy       = r_busy_out;
    assign o_pending_address   = r_pend_addr;

    // The write buffer only owns the port while it holds pending words.
    a_write_owner_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_owner == OWN_WRITE |-> r_busy)
        else $error("write buffer owns the port while empty");

    // A memory write leaves the port either still writing or released and empty.
    a_write_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_mem_write_valid |->
            (o_mem_state == STATE_WRITE) ||
            (o_mem_state == STATE_IDLE && !o_buffer_busy))
        else $error("memory write reported without write ownership");

    // An idle buffer reports an all-ones pending address.
    a_idle_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_buffer_busy |-> o_pending_address == 32'hffff_ffff)
        else $error("idle buffer reports a pending address");

    // A taken enqueue always leaves the buffer busy and writes nothing.
    a_enqueue_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_enqueue_accepted |-> o_buffer_busy && !o_mem_write_valid)
        else $error("accepted enqueue did not fill the buffer");

endmodule

// File: test/mpawb_port_checker.sv
// ----------------------------------------------------------------------------
// Memory port arbiter checker
// Watches the configuration, item and result channels of the arbiter, keeps
// its own copy of the owner machine and write buffer, and compares every
// result transfer field by field with the oldest predicted status.
// ----------------------------------------------------------------------------
module mpawb_port_checker import mpawb_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,

    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [1:0]  i_op,
    input  logic        i_d_fetching,
    input  logic        i_i_fetching,
    input  logic [3:0]  i_word_index,
    input  logic [31:0] i_word_data,
    input  logic [31:0] i_enqueue_address,
    input  logic        i_block_all_valid,

    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [1:0]  i_mem_state,
    input  logic        i_enqueue_accepted,
    input  logic        i_mem_write_valid,
    input  logic [31:0] i_mem_write_address,
    input  logic [31:0] i_mem_write_data,
    input  logic        i_buffer_busy,
    input  logic [31:0] i_pending_address,

    output int          o_mismatch_count,
    output int          o_results_pending,
    output logic        o_predicted_busy
);

    typedef struct packed {
        logic [1:0]  mem_state;
        logic        accepted;
        logic        wr_valid;
        logic [31:0] wr_addr;
        logic [31:0] wr_data;
        logic        busy;
        logic [31:0] pend_addr;
    } t_port_status;

    logic        cfg_write_back;
    logic [7:0]  cfg_first_pen;
    logic [7:0]  cfg_later_pen;
    logic [4:0]  cfg_block_words;

    logic [1:0]  owner;
    logic        buf_busy;
    logic [7:0]  wait_cnt;
    logic [3:0]  burst_pos;
    logic [31:0] next_addr;
    logic [31:0] staged [MAX_BLOCK_WORDS];

    t_port_status due_status [$];
    t_port_status want;
    int           mismatches = 0;
    int           n_due = 0;
    int           n_seen = 0;

    assign o_mismatch_count  = mismatches;
    assign o_results_pending = n_due;
    assign o_predicted_busy  = buf_busy;

    function automatic int burst_words();
        if (cfg_block_words == 5'd0) return 1;
        if (cfg_block_words > 5'(MAX_BLOCK_WORDS)) return MAX_BLOCK_WORDS;
        return int'(cfg_block_words);
    endfunction

    // Write-back bursts start on a power-of-two block boundary.
    function automatic logic [31:0] align_mask();
        logic [31:0] span;
        span = 32'd1;
        while (span < 32'(burst_words())) span = span << 1;
        return ~((span << 2) - 32'd1);
    endfunction

    function automatic void arbitrate(input logic dq, input logic iq);
        case (owner)
            STATE_IDLE: begin
                if (dq) owner = STATE_DATA;
                else if (iq) owner = STATE_INSTR;
                else if (buf_busy) owner = STATE_WRITE;
            end
            STATE_DATA: begin
                if (!dq) begin
                    if (iq) owner = STATE_INSTR;
                    else if (buf_busy) owner = STATE_WRITE;
                    else owner = STATE_IDLE;
                end
            end
            STATE_INSTR: begin
                if (!iq) begin
                    if (dq) owner = STATE_DATA;
                    else if (buf_busy) owner = STATE_WRITE;
                    else owner = STATE_IDLE;
                end
            end
            default: begin
                if (!buf_busy) begin
                    if (dq) owner = STATE_DATA;
                    else if (iq) owner = STATE_INSTR;
                    else owner = STATE_IDLE;
                end
            end
        endcase
    endfunction

    function automatic t_port_status advance_port(
        input logic [1:0]  op,
        input logic        dq,
        input logic        iq,
        input logic [3:0]  idx,
        input logic [31:0] data,
        input logic [31:0] addr,
        input logic        all_valid
    );
        t_port_status r;
        logic         fire;
        logic         more;
        logic [3:0]   last;
        r = '0;
        case (op)
            OP_TICK: begin
                arbitrate(dq, iq);
                if (buf_busy && owner == STATE_WRITE) begin
                    last     = 4'(burst_words() - 1);
                    wait_cnt = wait_cnt + 8'd1;
                    if (burst_pos == 4'd0) fire = (wait_cnt == cfg_first_pen);
                    else fire = (wait_cnt == cfg_later_pen);
                    if (fire) begin
                        r.wr_valid = 1'b1;
                        r.wr_addr  = next_addr;
                        r.wr_data  = staged[burst_pos];
                        wait_cnt   = 8'd0;
                        // Only the first word looks at the policy; later words
                        // run to the end of the block.
                        if (burst_pos == 4'd0) more = cfg_write_back && last != 4'd0;
                        else more = (burst_pos != last);
                        if (more) begin
                            next_addr = next_addr + 32'd4;
                            burst_pos = burst_pos + 4'd1;
                        end else begin
                            buf_busy = 1'b0;
                            owner    = STATE_IDLE;
                        end
                    end
                end
            end
            OP_LOAD: begin
                if (!buf_busy) staged[idx] = data;
            end
            OP_ENQUEUE: begin
                if (!buf_busy && all_valid) begin
                    if (cfg_write_back) begin
                        next_addr = addr & align_mask();
                    end else begin
                        next_addr = addr;
                        staged[0] = data;
                    end
                    buf_busy   = 1'b1;
                    wait_cnt   = 8'd0;
                    burst_pos  = 4'd0;
                    r.accepted = 1'b1;
                end
            end
            default: ;
        endcase
        r.mem_state = owner;
        r.busy      = buf_busy;
        r.pend_addr = buf_busy ? next_addr : 32'hffff_ffff;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] exp_val,
                                        input logic [31:0] act_val);
        if (exp_val !== act_val) begin
            mismatches++;
            if (mismatches <= 10)
                $display("result %0d %s: expected 0x%h, actual 0x%h",
                         n_seen, name, exp_val, act_val);
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_write_back  = 1'b1;
            cfg_first_pen   = 8'd30;
            cfg_later_pen   = 8'd2;
            cfg_block_words = 5'd4;
            owner           = STATE_IDLE;
            buf_busy        = 1'b0;
            wait_cnt        = 8'd0;
            burst_pos       = 4'd0;
            next_addr       = 32'd0;
            due_status.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_WRITE_BACK:    cfg_write_back  = i_cfg_data[0];
                    CFG_FIRST_PENALTY: cfg_first_pen   = i_cfg_data;
                    CFG_LATER_PENALTY: cfg_later_pen   = i_cfg_data;
                    CFG_BLOCK_WORDS:   cfg_block_words = i_cfg_data[4:0];
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                n_seen++;
                if (due_status.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d arrived with nothing outstanding", n_seen);
                end else begin
                    want = due_status.pop_front();
                    check_field("mem_state", 32'(want.mem_state), 32'(i_mem_state));
                    check_field("enqueue_accepted", 32'(want.accepted),
                                32'(i_enqueue_accepted));
                    check_field("mem_write_valid", 32'(want.wr_valid),
                                32'(i_mem_write_valid));
                    check_field("mem_write_address", want.wr_addr, i_mem_write_address);
                    check_field("mem_write_data", want.wr_data, i_mem_write_data);
                    check_field("buffer_busy", 32'(want.busy), 32'(i_buffer_busy));
                    check_field("pending_address", want.pend_addr, i_pending_address);
                end
            end
            if (i_in_valid && i_in_ready)
                due_status.push_back(advance_port(i_op, i_d_fetching, i_i_fetching,
                                                  i_word_index, i_word_data,
                                                  i_enqueue_address, i_block_all_valid));
        end
        n_due = due_status.size();
    end

endmodule

// File: test/tb_memory_port_arbiter_write_buffer_unit.sv
// ----------------------------------------------------------------------------
// Memory port arbiter testbench
// Drives directed and random fetch, load and enqueue traffic through several
// write buffer settings with bursty input and a stalling result sink; the
// checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_memory_port_arbiter_write_buffer_unit;
    import mpawb_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int WATCHDOG_LIMIT    = 2000;
    localparam int MAX_GAP           = 12;
    localparam int MAX_BURST         = 40;

    typedef enum logic [1:0] {
        SINK_ALWAYS,
        SINK_RANDOM,
        SINK_PERIODIC
    } t_sink_mode;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = CFG_WRITE_BACK;
    logic [7:0]  i_cfg_data = 8'd0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [1:0]  i_op = OP_TICK;
    logic        i_d_fetching = 1'b0;
    logic        i_i_fetching = 1'b0;
    logic [3:0]  i_word_index = 4'd0;
    logic [31:0] i_word_data = 32'd0;
    logic [31:0] i_enqueue_address = 32'd0;
    logic        i_block_all_valid = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [1:0]  o_mem_state;
    logic        o_enqueue_accepted;
    logic        o_mem_write_valid;
    logic [31:0] o_mem_write_address;
    logic [31:0] o_mem_write_data;
    logic        o_buffer_busy;
    logic [31:0] o_pending_address;

    int          mismatch_count;
    int          results_pending;
    logic        predicted_busy;

    int          burst_left = 0;
    logic        buffer_still_busy = 1'b0;
    int          idle_cycles = 0;
    t_sink_mode  sink_mode = SINK_ALWAYS;
    int          sink_left = 0;

    memory_port_arbiter_write_buffer_unit u_top (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_op                (i_op),
        .i_d_fetching        (i_d_fetching),
        .i_i_fetching        (i_i_fetching),
        .i_word_index        (i_word_index),
        .i_word_data         (i_word_data),
        .i_enqueue_address   (i_enqueue_address),
        .i_block_all_valid   (i_block_all_valid),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_mem_state         (o_mem_state),
        .o_enqueue_accepted  (o_enqueue_accepted),
        .o_mem_write_valid   (o_mem_write_valid),
        .o_mem_write_address (o_mem_write_address),
        .o_mem_write_data    (o_mem_write_data),
        .o_buffer_busy       (o_buffer_busy),
        .o_pending_address   (o_pending_address)
    );

    mpawb_port_checker u_checker (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_valid         (i_cfg_valid),
        .i_cfg_ready         (o_cfg_ready),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_in_valid          (i_in_valid),
        .i_in_ready          (o_in_ready),
        .i_op                (i_op),
        .i_d_fetching        (i_d_fetching),
        .i_i_fetching        (i_i_fetching),
        .i_word_index        (i_word_index),
        .i_word_data         (i_word_data),
        .i_enqueue_address   (i_enqueue_address),
        .i_block_all_valid   (i_block_all_valid),
        .i_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .i_mem_state         (o_mem_state),
        .i_enqueue_accepted  (o_enqueue_accepted),
        .i_mem_write_valid   (o_mem_write_valid),
        .i_mem_write_address (o_mem_write_address),
        .i_mem_write_data    (o_mem_write_data),
        .i_buffer_busy       (o_buffer_busy),
        .i_pending_address   (o_pending_address),
        .o_mismatch_count    (mismatch_count),
        .o_results_pending   (results_pending),
        .o_predicted_busy    (predicted_busy)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // The result sink switches between stretches of full rate, random stalls
    // and a fixed stall pattern.
    always @(posedge i_clk) begin
        if (sink_left == 0) begin
            sink_mode <= t_sink_mode'($urandom_range(0, 2));
            sink_left <= $urandom_range(8, 60);
        end else begin
            sink_left <= sink_left - 1;
        end
        case (sink_mode)
            SINK_ALWAYS:   i_out_ready <= 1'b1;
            SINK_RANDOM:   i_out_ready <= ($urandom_range(0, 99) < 60);
            default:       i_out_ready <= (sink_left[1:0] != 2'd0);
        endcase
    end

    initial begin
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_in_valid && o_in_ready) || (i_cfg_valid && o_cfg_ready)
                || (o_out_valid && i_out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("FAILURE");
        $finish;
    end

    function automatic logic chance(input int pct);
        return ($urandom_range(0, 99) < pct);
    endfunction

    task automatic push_item(
        input logic [1:0]  op,
        input logic        d_req,
        input logic        i_req,
        input logic [3:0]  idx,
        input logic [31:0] data,
        input logic [31:0] addr,
        input logic        all_valid
    );
        int gap;
        if (burst_left == 0) begin
            gap = chance(25) ? 0 : $urandom_range(1, MAX_GAP);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, MAX_BURST);
        end
        i_op              <= op;
        i_d_fetching      <= d_req;
        i_i_fetching      <= i_req;
        i_word_index      <= idx;
        i_word_data       <= data;
        i_enqueue_address <= addr;
        i_block_all_valid <= all_valid;
        i_in_valid        <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        burst_left--;
    endtask

    task automatic push_tick();
        push_item(OP_TICK, 1'b0, 1'b0, 4'($urandom), $urandom, $urandom, chance(50));
    endtask

    task automatic push_random(input int tick_pct, input int fetch_pct);
        int          roll;
        int          rest;
        int          pick;
        logic [1:0]  op;
        logic [31:0] addr;
        roll = $urandom_range(0, 99);
        rest = 100 - tick_pct;
        if (roll < tick_pct) op = OP_TICK;
        else if (roll < tick_pct + rest * 4 / 10) op = OP_LOAD;
        else if (roll < tick_pct + rest * 9 / 10) op = OP_ENQUEUE;
        else op = OP_UNUSED;
        pick = $urandom_range(0, 9);
        if (pick == 0) addr = 32'd0;
        else if (pick == 1) addr = 32'hffff_ffff;
        else addr = $urandom;
        push_item(op, chance(fetch_pct), chance(fetch_pct), 4'($urandom_range(0, 15)),
                  $urandom, addr, chance(85));
    endtask

    // Holds the input side until every predicted result has been seen.
    task automatic wait_results_done();
        i_in_valid <= 1'b0;
        burst_left = 0;
        do @(negedge i_clk); while (results_pending != 0);
        buffer_still_busy = predicted_busy;
        @(posedge i_clk);
    endtask

    // Ticks without fetch traffic until the write buffer has emptied, so that
    // a new block size never meets a burst in progress.
    task automatic flush_buffer();
        wait_results_done();
        while (buffer_still_busy) begin
            push_tick();
            wait_results_done();
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] value);
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic run_phase(input logic wb, input logic [7:0] first_pen,
                             input logic [7:0] later_pen, input logic [7:0] words,
                             input int n_items, input int tick_pct, input int fetch_pct);
        flush_buffer();
        write_reg(CFG_WRITE_BACK, {7'd0, wb});
        write_reg(CFG_FIRST_PENALTY, first_pen);
        write_reg(CFG_LATER_PENALTY, later_pen);
        write_reg(CFG_BLOCK_WORDS, words);
        i_cfg_valid <= 1'b0;
        repeat (n_items) push_random(tick_pct, fetch_pct);
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Stage every slot once so that no burst ever reads an unloaded word.
        for (int k = 0; k < MAX_BLOCK_WORDS; k++)
            push_item(OP_LOAD, chance(50), chance(50), 4'(k),
                      (k == 0) ? 32'hffff_ffff : (k == 1) ? 32'd0 : $urandom,
                      $urandom, chance(50));

        push_item(OP_UNUSED, 1'b1, 1'b1, 4'hf, 32'hffff_ffff, 32'hffff_ffff, 1'b1);
        push_item(OP_TICK, 1'b1, 1'b1, 4'h0, 32'd0, 32'd0, 1'b0);
        push_item(OP_TICK, 1'b1, 1'b0, 4'h0, 32'd0, 32'd0, 1'b0);
        push_item(OP_TICK, 1'b0, 1'b1, 4'h0, 32'd0, 32'd0, 1'b0);
        push_item(OP_TICK, 1'b1, 1'b1, 4'h0, 32'd0, 32'd0, 1'b0);
        push_item(OP_TICK, 1'b1, 1'b0, 4'h0, 32'd0, 32'd0, 1'b0);
        push_item(OP_TICK, 1'b0, 1'b0, 4'h0, 32'd0, 32'd0, 1'b0);
        // A block that is not all valid is refused; the next one is taken.
        push_item(OP_ENQUEUE, 1'b0, 1'b0, 4'h0, 32'd0, 32'hffff_ffff, 1'b0);
        push_item(OP_ENQUEUE, 1'b0, 1'b0, 4'h0, 32'hffff_ffff, 32'hffff_ffff, 1'b1);
        push_item(OP_LOAD, 1'b0, 1'b0, 4'h3, 32'd0, 32'd0, 1'b1);
        push_item(OP_ENQUEUE, 1'b0, 1'b0, 4'h0, 32'd0, 32'd0, 1'b1);
        push_item(OP_TICK, 1'b0, 1'b0, 4'h0, 32'd0, 32'd0, 1'b0);
        push_item(OP_TICK, 1'b1, 1'b1, 4'h0, 32'd0, 32'd0, 1'b0);
        push_item(OP_UNUSED, 1'b0, 1'b0, 4'h0, 32'd0, 32'd0, 1'b0);
        repeat (60) push_random(70, 15);

        run_phase(1'b0, 8'd1, 8'd1, 8'd1, 60, 70, 15);
        run_phase(1'b1, 8'd1, 8'd1, 8'd16, 80, 70, 15);

        // Switch to write-through after the first two words of a full burst;
        // the rest of the block must still go out.
        flush_buffer();
        push_item(OP_ENQUEUE, 1'b0, 1'b0, 4'h0, $urandom, $urandom, 1'b1);
        push_tick();
        push_tick();
        wait_results_done();
        write_reg(CFG_WRITE_BACK, 8'd0);
        i_cfg_valid <= 1'b0;
        repeat (60) push_random(70, 15);

        run_phase(1'b1, 8'd255, 8'd1, 8'd16, 150, 95, 2);
        run_phase(1'b1, 8'd3, 8'd255, 8'd2, 150, 95, 2);
        run_phase(1'b1, 8'd0, 8'd0, 8'd0, 150, 95, 2);
        run_phase(1'b1, 8'd2, 8'd3, 8'd31, 60, 70, 15);
        run_phase(1'b1, 8'd4, 8'd2, 8'd3, 60, 70, 15);

        wait_results_done();
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// File: files.f
rtl/core/mpawb_pkg.sv
rtl/core/mpawb_arb.sv
rtl/core/memory_port_arbiter_write_buffer_unit.sv
test/mpawb_port_checker.sv
test/tb_memory_port_arbiter_write_buffer_unit.sv
